/* rtl/deadzone_camera_tracker_defines.svh */
// Assertion macros shared by the camera tracker RTL.
`ifndef DEADZONE_CAMERA_TRACKER_DEFINES_SVH
`define DEADZONE_CAMERA_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DCT_ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("camera tracker check failed");

// Next-cycle implication, disabled during reset.
`define DCT_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("camera tracker check failed");

`endif

/* rtl/dct_pkg.sv */
// Constants, request codes and helper functions of the camera tracker.
package dct_pkg;

  localparam int SCREEN_W  = 320;
  localparam int SCREEN_H  = 240;
  localparam int MIN_SPEED = 256;

  localparam int MUL_A_W = 42;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic signed [26:0] HALF_X = 27'(SCREEN_W * 128);
  localparam logic signed [26:0] HALF_Y = 27'(SCREEN_H * 128);
  localparam logic signed [26:0] FULL_X = 27'(SCREEN_W * 256);
  localparam logic signed [26:0] FULL_Y = 27'(SCREEN_H * 256);
  localparam logic [MUL_P_W-1:0] SPEED_THRESH = MUL_P_W'(MIN_SPEED * 256);

  localparam logic [1:0] REQ_UPDATE = 2'd0;
  localparam logic [1:0] REQ_MOVE   = 2'd1;
  localparam logic [1:0] REQ_SET    = 2'd2;
  localparam logic [1:0] REQ_SNAPF  = 2'd3;

  localparam logic [2:0] REG_DZ_W   = 3'd0;
  localparam logic [2:0] REG_DZ_H   = 3'd1;
  localparam logic [2:0] REG_LA_X   = 3'd2;
  localparam logic [2:0] REG_LA_Y   = 3'd3;
  localparam logic [2:0] REG_GAIN   = 3'd4;
  localparam logic [2:0] REG_SNAP   = 3'd5;
  localparam logic [2:0] REG_MAP_W  = 3'd6;
  localparam logic [2:0] REG_MAP_H  = 3'd7;

  function automatic logic signed [23:0] sat24(input logic signed [35:0] v);
    logic signed [23:0] r;
    if (v > 36'sd8388607) r = 24'sh7fffff;
    else if (v < -36'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  // Viewport target of an axis: focus minus half a screen, held in a nonzero map.
  function automatic logic signed [23:0] port_target(input logic signed [23:0] f,
                                                     input logic signed [26:0] half,
                                                     input logic signed [26:0] full,
                                                     input logic [15:0] map);
    logic signed [26:0] t;
    logic signed [26:0] hi;
    t  = $signed({{3{f[23]}}, f}) - half;
    hi = $signed({3'b000, map, 8'h00}) - full;
    if (map != 16'd0) begin
      if (t > hi) t = hi;
      else if (t < 27'sd0) t = 27'sd0;
    end
    return sat24(36'(t));
  endfunction

endpackage

/* rtl/dct_smul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module dct_smul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dct_pkg::MUL_A_W-1:0] a,
  input  logic [dct_pkg::MUL_B_W-1:0] b,
  output logic                        done,
  output logic [dct_pkg::MUL_P_W-1:0] p
);

  logic [dct_pkg::MUL_P_W-1:0] acc;
  logic [dct_pkg::MUL_P_W-1:0] aa;
  logic [dct_pkg::MUL_B_W-1:0] bb;
  logic [3:0]                  cnt;
  logic                        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 4'd0;
    end else begin
      done <= !start && busy && (cnt == 4'(dct_pkg::MUL_B_W - 1));
      if (start) begin
        acc  <= '0;
        aa   <= {{dct_pkg::MUL_B_W{1'b0}}, a};
        bb   <= b;
        cnt  <= 4'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (bb[0]) acc <= acc + aa;
        aa  <= aa << 1;
        bb  <= bb >> 1;
        cnt <= cnt + 4'd1;
        if (cnt == 4'(dct_pkg::MUL_B_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign p = acc;

endmodule

/* rtl/deadzone_camera_tracker.sv */
// Top level of the deadzone camera tracker: sequencer, state and ports.
//
//  channel | direction | handshake          | contents
//  in      | input     | in_valid/in_stall  | request word and entity box
//  out     | output    | out_valid/out_stall| viewport, focus, moved flag
//  cfg     | input     | cfg_we             | register index and data
//
// A move request goes from idle straight to the output state, a set request
// through the target and apply states first. An update runs the follow and
// focus states with a followed entity, then the target and a multiplier pass
// on its speed; easing adds four more multiplier passes, two for each axis.
// Input is taken only while idle.
// A finished word waits in the output register while the next one is taken.
// Synchronous reset clears the camera state and config; gain resets to 768.
`include "deadzone_camera_tracker_defines.svh"

module deadzone_camera_tracker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic               follow_valid,
  input  logic signed [23:0] ent_x,
  input  logic signed [23:0] ent_y,
  input  logic [17:0]        ent_w,
  input  logic [17:0]        ent_h,
  input  logic               grounded,
  input  logic signed [23:0] target_x,
  input  logic signed [23:0] target_y,
  input  logic [15:0]        frame_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] view_x,
  output logic signed [23:0] view_y,
  output logic signed [23:0] cam_x,
  output logic signed [23:0] cam_y,
  output logic               moved,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [17:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_FOLLOW, S_FOCUS, S_TARGET, S_MSUM,
    S_MX1, S_MX2, S_MY1, S_MY2, S_APPLY, S_DONE
  } state_t;

  state_t state;

  logic [17:0] dzw, dzh;
  logic [15:0] lax, lay, gain, mapw, maph;
  logic        snap;

  logic [1:0]         rq;
  logic               gnd;
  logic signed [23:0] ex, ey;
  logic [17:0]        ew, eh;
  logic [15:0]        ft;

  logic signed [23:0] zx, zy, ax, ay, fx, fy, px, py, opx, opy, tx, ty;
  logic signed [24:0] dx, dy;
  logic [41:0]        tmp;
  logic [33:0]        qx, qy;
  logic               ease;

  logic               mul_start, mul_start_next, mul_done;
  logic [41:0]        mul_a;
  logic [15:0]        mul_b;
  logic [57:0]        mul_p;

  logic signed [23:0] zx_next, zy_next, ax_next, ay_next;
  logic signed [26:0] ex27, ey27, zx27, zy27, lx, rx, ly, ry;
  logic [17:0]        sx, sy;
  logic [24:0]        adx, ady;
  logic signed [35:0] sqx, sqy;
  logic signed [23:0] tgt_x, tgt_y;
  logic               in_mul;

  assign in_stall = (state != S_IDLE);
  assign in_mul   = (state == S_MSUM) || (state == S_MX1) || (state == S_MX2) ||
                    (state == S_MY1) || (state == S_MY2);

  // Deadzone follow for both axes, with the optional platform snap on y.
  always_comb begin
    ex27 = {{3{ex[23]}}, ex};
    ey27 = {{3{ey[23]}}, ey};
    zx27 = {{3{zx[23]}}, zx};
    zy27 = {{3{zy[23]}}, zy};
    sx = (ew < dzw) ? ew : dzw;
    sy = (eh < dzh) ? eh : dzh;
    lx = ex27 + $signed({9'b0, sx});
    rx = zx27 + $signed({9'b0, dzw});
    ly = ey27 + $signed({9'b0, sy});
    ry = zy27 + $signed({9'b0, dzh});
    zx_next = zx;
    ax_next = ax;
    zy_next = zy;
    ay_next = ay;
    if (ex27 < zx27) begin
      zx_next = ex;
      ax_next = -$signed({8'b0, lax});
    end else if (lx > rx) begin
      zx_next = dct_pkg::sat24(36'(lx - $signed({9'b0, dzw})));
      ax_next = $signed({8'b0, lax});
    end
    if (ey27 < zy27) begin
      zy_next = ey;
      ay_next = -$signed({8'b0, lay});
    end else if (ly > ry) begin
      zy_next = dct_pkg::sat24(36'(ly - $signed({9'b0, dzh})));
      ay_next = $signed({8'b0, lay});
    end
    if (snap && gnd)
      zy_next = dct_pkg::sat24(36'(ey27 + $signed({9'b0, eh}) - $signed({9'b0, dzh})));
  end

  always_comb begin
    tgt_x = dct_pkg::port_target(fx, dct_pkg::HALF_X, dct_pkg::FULL_X, mapw);
    tgt_y = dct_pkg::port_target(fy, dct_pkg::HALF_Y, dct_pkg::FULL_Y, maph);
  end

  always_comb begin
    adx = dx[24] ? 25'(-dx) : 25'(dx);
    ady = dy[24] ? 25'(-dy) : 25'(dy);
    sqx = dx[24] ? -$signed({2'b0, qx}) : $signed({2'b0, qx});
    sqy = dy[24] ? -$signed({2'b0, qy}) : $signed({2'b0, qy});
    unique case (state) inside
      S_MSUM:  begin mul_a = {17'b0, adx} + {17'b0, ady}; mul_b = gain; end
      S_MX1:   begin mul_a = {17'b0, adx};                mul_b = gain; end
      S_MY1:   begin mul_a = {17'b0, ady};                mul_b = gain; end
      S_MX2, S_MY2: begin mul_a = tmp;                    mul_b = ft;   end
      default: begin mul_a = '0;                          mul_b = '0;   end
    endcase
  end

  // A multiplier pass starts on the cycle after the state that asks for it.
  always_comb begin
    mul_start_next = 1'b0;
    unique case (state) inside
      S_TARGET:           mul_start_next = (rq != dct_pkg::REQ_SET);
      S_MSUM:             mul_start_next = mul_done && (mul_p > dct_pkg::SPEED_THRESH);
      S_MX1, S_MX2, S_MY1: mul_start_next = mul_done;
      default:            mul_start_next = 1'b0;
    endcase
  end

  dct_smul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
      dzw <= '0; dzh <= '0; lax <= '0; lay <= '0;
      gain <= 16'd768; snap <= 1'b0; mapw <= '0; maph <= '0;
      zx <= '0; zy <= '0; ax <= '0; ay <= '0;
      fx <= '0; fy <= '0; px <= '0; py <= '0;
    end else begin
      mul_start <= mul_start_next;
      if (state == S_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          dct_pkg::REG_DZ_W:  dzw  <= cfg_data;
          dct_pkg::REG_DZ_H:  dzh  <= cfg_data;
          dct_pkg::REG_LA_X:  lax  <= cfg_data[15:0];
          dct_pkg::REG_LA_Y:  lay  <= cfg_data[15:0];
          dct_pkg::REG_GAIN:  gain <= cfg_data[15:0];
          dct_pkg::REG_SNAP:  snap <= cfg_data[0];
          dct_pkg::REG_MAP_W: mapw <= cfg_data[15:0];
          dct_pkg::REG_MAP_H: maph <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rq <= req_type; gnd <= grounded;
            ex <= ent_x; ey <= ent_y; ew <= ent_w; eh <= ent_h; ft <= frame_time;
            opx <= px; opy <= py;
            unique case (req_type)
              dct_pkg::REQ_MOVE: begin
                fx <= target_x; fy <= target_y;
                state <= S_DONE;
              end
              dct_pkg::REQ_SET: begin
                fx <= target_x; fy <= target_y;
                state <= S_TARGET;
              end
              default: state <= follow_valid ? S_FOLLOW : S_TARGET;
            endcase
          end
        end
        S_FOLLOW: begin
          zx <= zx_next; zy <= zy_next; ax <= ax_next; ay <= ay_next;
          state <= S_FOCUS;
        end
        S_FOCUS: begin
          fx <= dct_pkg::sat24(36'(zx27 + $signed({10'b0, dzw[17:1]}) +
                                   $signed({{3{ax[23]}}, ax})));
          fy <= dct_pkg::sat24(36'(zy27 + $signed({10'b0, dzh[17:1]}) +
                                   $signed({{3{ay[23]}}, ay})));
          state <= S_TARGET;
        end
        S_TARGET: begin
          tx <= tgt_x;
          ty <= tgt_y;
          dx <= $signed({tgt_x[23], tgt_x}) - $signed({px[23], px});
          dy <= $signed({tgt_y[23], tgt_y}) - $signed({py[23], py});
          ease <= 1'b0;
          if (rq == dct_pkg::REQ_SET) begin
            state <= S_APPLY;
          end else begin
            state <= S_MSUM;
          end
        end
        S_MSUM: begin
          if (mul_done) begin
            if (mul_p > dct_pkg::SPEED_THRESH) begin
              state <= S_MX1;
            end else begin
              state <= S_APPLY;
            end
          end
        end
        S_MX1: begin
          if (mul_done) begin
            tmp <= mul_p[41:0]; state <= S_MX2;
          end
        end
        S_MX2: begin
          if (mul_done) begin
            qx <= mul_p[57:24]; state <= S_MY1;
          end
        end
        S_MY1: begin
          if (mul_done) begin
            tmp <= mul_p[41:0]; state <= S_MY2;
          end
        end
        S_MY2: begin
          if (mul_done) begin
            qy <= mul_p[57:24]; ease <= 1'b1; state <= S_APPLY;
          end
        end
        S_APPLY: begin
          // A snapping request overrides any easing of the viewport.
          if (rq == dct_pkg::REQ_SET || rq == dct_pkg::REQ_SNAPF) begin
            px <= tx; py <= ty;
          end else if (ease) begin
            px <= dct_pkg::sat24(36'(px) + sqx);
            py <= dct_pkg::sat24(36'(py) + sqy);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            view_x <= px; view_y <= py; cam_x <= fx; cam_y <= fy;
            moved  <= (px != opx) || (py != opy);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DCT_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_valid && !in_stall, state != S_IDLE)
  `DCT_ASSERT_SAME(a_mul_done_in_mul, clk, rst, mul_done, in_mul)
  `DCT_ASSERT_NEXT(a_move_no_motion, clk, rst, state == S_APPLY && rq == dct_pkg::REQ_MOVE, 1'b0)

endmodule

/* test/tb_deadzone_camera_tracker.sv */
// Self-checking testbench for the deadzone camera tracker: predicted camera state against the block.
`timescale 1ns / 100ps

module tb_deadzone_camera_tracker;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [1:0]         req;
    logic               follow;
    logic signed [23:0] ex, ey;
    logic [17:0]        ew, eh;
    logic               ground;
    logic signed [23:0] tx, ty;
    logic [15:0]        ft;
  } frame_t;

  typedef struct {
    logic signed [23:0] vx, vy, cx, cy;
    logic               mv;
  } view_t;

  // Tracks the camera state and queues the view each request should produce.
  class camera_scoreboard;
    longint dz_w, dz_h, la_x, la_y, gain, snap, map_w, map_h;
    longint zx, zy, ax, ay, fx, fy, px, py;
    view_t  pending[$];
    int     errors;
    int     checked;

    function void clear();
      dz_w = 0; dz_h = 0; la_x = 0; la_y = 0; gain = 768; snap = 0;
      map_w = 0; map_h = 0;
      zx = 0; zy = 0; ax = 0; ay = 0; fx = 0; fy = 0; px = 0; py = 0;
      pending.delete();
      errors = 0;
      checked = 0;
    endfunction

    function longint clip(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    function longint absv(longint v);
      return v < 0 ? -v : v;
    endfunction

    function void write_reg(logic [2:0] idx, logic [17:0] d);
      case (idx)
        dct_pkg::REG_DZ_W:  dz_w = d;
        dct_pkg::REG_DZ_H:  dz_h = d;
        dct_pkg::REG_LA_X:  la_x = d[15:0];
        dct_pkg::REG_LA_Y:  la_y = d[15:0];
        dct_pkg::REG_GAIN:  gain = d[15:0];
        dct_pkg::REG_SNAP:  snap = d[0];
        dct_pkg::REG_MAP_W: map_w = d[15:0];
        default:            map_h = d[15:0];
      endcase
    endfunction

    function void chase(longint p, longint sz, longint zs, longint la,
                        ref longint z, ref longint a);
      longint s;
      s = sz < zs ? sz : zs;
      if (p < z) begin
        z = p;
        a = -la;
      end else if (p + s > z + zs) begin
        z = clip(p + s - zs);
        a = la;
      end
    endfunction

    function longint aim(longint f, longint scr, longint mp);
      longint t, hi;
      t = f - scr * 128;
      if (mp != 0) begin
        hi = mp * 256 - scr * 256;
        if (t > hi) t = hi;
        else if (t < 0) t = 0;
      end
      return clip(t);
    endfunction

    function longint ease(longint d, longint ft);
      longint q;
      q = longint'((64'(absv(d)) * 64'(gain) * 64'(ft)) >> 24);
      return d < 0 ? -q : q;
    endfunction

    function void follow(frame_t f);
      longint dx, dy;
      if (f.follow) begin
        chase(f.ex, f.ew, dz_w, la_x, zx, ax);
        chase(f.ey, f.eh, dz_h, la_y, zy, ay);
        if (snap != 0 && f.ground) zy = clip(longint'(f.ey) + f.eh - dz_h);
        fx = clip(zx + (dz_w >> 1) + ax);
        fy = clip(zy + (dz_h >> 1) + ay);
      end
      dx = aim(fx, dct_pkg::SCREEN_W, map_w) - px;
      dy = aim(fy, dct_pkg::SCREEN_H, map_h) - py;
      if (absv(dx) * gain + absv(dy) * gain > (longint'(dct_pkg::MIN_SPEED) << 8)) begin
        px = clip(px + ease(dx, f.ft));
        py = clip(py + ease(dy, f.ft));
      end
    endfunction

    function void note_frame(frame_t f);
      longint ox, oy;
      view_t v;
      ox = px;
      oy = py;
      case (f.req)
        dct_pkg::REQ_UPDATE: follow(f);
        dct_pkg::REQ_MOVE: begin
          fx = f.tx;
          fy = f.ty;
        end
        dct_pkg::REQ_SET: begin
          fx = f.tx;
          fy = f.ty;
          px = aim(fx, dct_pkg::SCREEN_W, map_w);
          py = aim(fy, dct_pkg::SCREEN_H, map_h);
        end
        default: begin
          follow(f);
          px = aim(fx, dct_pkg::SCREEN_W, map_w);
          py = aim(fy, dct_pkg::SCREEN_H, map_h);
        end
      endcase
      v.vx = px[23:0];
      v.vy = py[23:0];
      v.cx = fx[23:0];
      v.cy = fy[23:0];
      v.mv = (px != ox) || (py != oy);
      pending.push_back(v);
    endfunction

    function void check_view(view_t got);
      view_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word vx=%0d vy=%0d", $time, got.vx, got.vy);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.vx !== e.vx) begin
        $display("%0t: view_x expected %0d got %0d", $time, e.vx, got.vx);
        errors++;
      end
      if (got.vy !== e.vy) begin
        $display("%0t: view_y expected %0d got %0d", $time, e.vy, got.vy);
        errors++;
      end
      if (got.cx !== e.cx) begin
        $display("%0t: cam_x expected %0d got %0d", $time, e.cx, got.cx);
        errors++;
      end
      if (got.cy !== e.cy) begin
        $display("%0t: cam_y expected %0d got %0d", $time, e.cy, got.cy);
        errors++;
      end
      if (got.mv !== e.mv) begin
        $display("%0t: moved expected %0b got %0b", $time, e.mv, got.mv);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = '0;
  logic follow_valid = 1'b0;
  logic signed [23:0] ent_x = '0, ent_y = '0, target_x = '0, target_y = '0;
  logic [17:0] ent_w = '0, ent_h = '0;
  logic grounded = 1'b0;
  logic [15:0] frame_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] view_x, view_y, cam_x, cam_y;
  logic moved;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [17:0] cfg_data = '0;

  camera_scoreboard sb;
  int idle_cycles = 0;
  int frames_sent;
  bit sink_hold;
  bit sink_free;

  deadzone_camera_tracker u_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.note_frame('{req_type, follow_valid, ent_x, ent_y, ent_w, ent_h,
                        grounded, target_x, target_y, frame_time});
        idle_cycles <= 0;
      end else if (out_valid && !out_stall) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && !out_stall) sb.check_view('{view_x, view_y, cam_x, cam_y, moved});
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d words outstanding", sb.pending.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request.
  always @(negedge clk) begin
    if (sink_hold) out_stall <= 1'b1;
    else if (sink_free) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  task automatic write_reg(logic [2:0] idx, logic [17:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, d);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic send(frame_t f, bit keep);
    req_type <= f.req;
    follow_valid <= f.follow;
    ent_x <= f.ex;
    ent_y <= f.ey;
    ent_w <= f.ew;
    ent_h <= f.eh;
    grounded <= f.ground;
    target_x <= f.tx;
    target_y <= f.ty;
    frame_time <= f.ft;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (!keep) in_valid <= 1'b0;
    frames_sent++;
  endtask

  function automatic logic signed [23:0] any_pos(logic signed [23:0] base);
    case ($urandom_range(0, 5))
      0: return 24'sh7fffff - 24'($urandom_range(0, 255));
      1: return 24'sh800000 + 24'($urandom_range(0, 255));
      2: return 24'($urandom);
      default: return base + 24'($signed($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  // Mostly a walking entity with follow enabled, with some wild boxes mixed in.
  function automatic frame_t random_frame(logic signed [23:0] bx, logic signed [23:0] by);
    frame_t f;
    f.req    = ($urandom_range(0, 9) < 7) ? dct_pkg::REQ_UPDATE : 2'($urandom_range(1, 3));
    f.follow = ($urandom_range(0, 7) != 0);
    f.ex     = any_pos(bx);
    f.ey     = any_pos(by);
    f.ew     = ($urandom_range(0, 7) == 0) ? 18'($urandom) : 18'($urandom_range(0, 16384));
    f.eh     = ($urandom_range(0, 7) == 0) ? 18'($urandom) : 18'($urandom_range(0, 16384));
    f.ground = 1'($urandom_range(0, 1));
    f.tx     = any_pos(bx);
    f.ty     = any_pos(by);
    case ($urandom_range(0, 3))
      0: f.ft = 16'hffff;
      1: f.ft = 16'($urandom);
      default: f.ft = 16'($urandom_range(500, 2500));
    endcase
    return f;
  endfunction

  task automatic random_phase(int count);
    frame_t f;
    logic signed [23:0] bx, by;
    int burst;
    bx = 24'($urandom);
    by = 24'($urandom);
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && count > 0) begin
        f = random_frame(bx, by);
        bx = f.ex;
        by = f.ey;
        send(f, burst > 1 && count > 1);
        burst--;
        count--;
      end
      in_valid <= 1'b0;
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  endtask

  task automatic config_all(logic [17:0] dw, logic [17:0] dh, logic [15:0] lx,
                            logic [15:0] ly, logic [15:0] g, logic s,
                            logic [15:0] mw, logic [15:0] mh);
    write_reg(dct_pkg::REG_DZ_W, dw);
    write_reg(dct_pkg::REG_DZ_H, dh);
    write_reg(dct_pkg::REG_LA_X, 18'(lx));
    write_reg(dct_pkg::REG_LA_Y, 18'(ly));
    write_reg(dct_pkg::REG_GAIN, 18'(g));
    write_reg(dct_pkg::REG_SNAP, 18'(s));
    write_reg(dct_pkg::REG_MAP_W, 18'(mw));
    write_reg(dct_pkg::REG_MAP_H, 18'(mh));
  endtask

  initial begin
    frame_t f;
    sb = new();
    sb.clear();
    frames_sent = 0;
    sink_hold = 1'b0;
    sink_free = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset settings first, then every request and the corner cases.
    sink_free = 1'b1;
    f = '{dct_pkg::REQ_UPDATE, 1'b1, 24'sd2560, 24'sd1280, 18'd4096, 18'd8192, 1'b0,
          24'sd0, 24'sd0, 16'd0};
    send(f, 1'b0);
    drain();
    config_all(18'd16384, 18'd12288, 16'd2048, 16'd1024, 16'd768, 1'b1, 16'd1000, 16'd800);
    f = '{dct_pkg::REQ_UPDATE, 1'b1, 24'sd40000, 24'sd30000, 18'd4096, 18'd8192, 1'b1,
          24'sd0, 24'sd0, 16'd1092};
    send(f, 1'b0);
    f.ex = -24'sd40000; f.ground = 1'b0; send(f, 1'b0);
    f.follow = 1'b0; send(f, 1'b0);
    f = '{dct_pkg::REQ_MOVE, 1'b0, 24'sd0, 24'sd0, 18'd0, 18'd0, 1'b0, 24'sd100000,
          -24'sd5000, 16'd0};
    send(f, 1'b0);
    f.req = dct_pkg::REQ_SET; f.tx = 24'sh7fffff; f.ty = 24'sh800000; send(f, 1'b0);
    f = '{dct_pkg::REQ_SNAPF, 1'b1, 24'sh7fffff, 24'sh7fffff, 18'h3ffff, 18'h3ffff, 1'b1,
          24'sd0, 24'sd0, 16'hffff};
    send(f, 1'b0);
    f.ex = 24'sh800000; f.ey = 24'sh800000; f.req = dct_pkg::REQ_UPDATE; send(f, 1'b0);
    drain();
    // Map smaller than the screen, maximum gain and deadzone.
    config_all(18'h3ffff, 18'h3ffff, 16'hffff, 16'hffff, 16'hffff, 1'b0, 16'd100, 16'd50);
    f = '{dct_pkg::REQ_UPDATE, 1'b1, 24'sh7fff00, 24'sh800000, 18'h3ffff, 18'd0, 1'b1,
          24'sd0, 24'sd0, 16'hffff};
    send(f, 1'b0);
    f.req = dct_pkg::REQ_SNAPF; f.ex = 24'sh800000; send(f, 1'b0);
    f.req = dct_pkg::REQ_SET; f.tx = 24'sd12345; f.ty = -24'sd777; send(f, 1'b0);
    drain();
    config_all(18'd0, 18'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'hffff, 16'hffff);
    f = '{dct_pkg::REQ_UPDATE, 1'b1, 24'sd5000, 24'sd7000, 18'd0, 18'd0, 1'b0,
          24'sd0, 24'sd0, 16'd30000};
    send(f, 1'b0);
    f.req = dct_pkg::REQ_MOVE; f.tx = -24'sd1; f.ty = 24'sd1; send(f, 1'b0);
    drain();
    sink_free = 1'b0;

    // Random phases over several settings.
    for (int ph = 0; ph < 8; ph++) begin
      config_all(18'($urandom_range(0, 20000)), 18'($urandom_range(0, 20000)),
                 16'($urandom), 16'($urandom), 16'($urandom_range(0, 4000)),
                 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom),
                 ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom));
      if (ph == 3) begin
        // Long receiver hold-off while requests keep coming.
        fork
          begin
            sink_hold = 1'b1;
            repeat (600) @(negedge clk);
            sink_hold = 1'b0;
          end
          random_phase(40);
        join
      end
      random_phase(190);
      in_valid <= 1'b0;
      drain();
    end

    in_valid <= 1'b0;
    drain();
    $display("Sent %0d requests of every kind over eight random register settings,",
             frames_sent);
    $display("including extremes and a long output hold-off; %0d words checked.", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
